/* rtl/aetdc_pkg.sv */
// Package: character codes, result kinds and the VGA palette for the escape parser.
`default_nettype none

package aetdc_pkg;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_J    = 8'h4A;
	localparam logic [7:0] CH_H    = 8'h48;

	localparam logic [2:0] KIND_TEXT     = 3'd0;
	localparam logic [2:0] KIND_SETCOL   = 3'd1;
	localparam logic [2:0] KIND_RESETCOL = 3'd2;
	localparam logic [2:0] KIND_CLEAR    = 3'd3;
	localparam logic [2:0] KIND_HOME     = 3'd4;

	localparam int unsigned NUM_W = 10;
	localparam logic [NUM_W-1:0] NUM_MAX = 10'd1023;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'b001,
		PH_ESC    = 3'b010,
		PH_CSI    = 3'b100
	} phase_t;

	function automatic logic [3:0] vga_color(input logic [2:0] idx, input logic bright);
		logic [2:0] base;
		begin
			unique case (idx)
				3'd0: base = 3'h0;
				3'd1: base = 3'h4;
				3'd2: base = 3'h2;
				3'd3: base = 3'h6;
				3'd4: base = 3'h1;
				3'd5: base = 3'h5;
				3'd6: base = 3'h3;
				3'd7: base = 3'h7;
				default: base = 3'h0;
			endcase
			vga_color = {bright, base};
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/ansi_escape_to_display_cmd_core.sv */
// Top level: ANSI CSI escape parser turning a byte stream into text-mode display commands.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | sink      | in_valid / in_stall  | byte_in
//   out     | source    | out_valid / out_stall| kind, text_byte, fg_color, last
//   cfg     | sink      | cfg_valid / cfg_ready| escape_parsing_enable
//
// One byte per cycle unless stalled by the output or a pending home: a byte is registered
// in the input register, then its result moves to the output register. Clear screen yields
// two results and holds the input register while the cursor home request is pending.
// arst_n clears the parser to the text phase and sets parsing on.
// Output stall backs up into in_stall within the same cycle; no request is dropped.
`default_nettype none

module ansi_escape_to_display_cmd_core
	import aetdc_pkg::*;
#(
	parameter int unsigned MAX_PARAM_CHARS = 15
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] byte_in,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [2:0] kind,
	output      logic [7:0] text_byte,
	output      logic [3:0] fg_color,
	output      logic       last,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic       escape_parsing_enable
);

	localparam int unsigned CNT_W = $clog2(MAX_PARAM_CHARS + 1);

	logic             en_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [NUM_W-1:0] num_q, num_d;
	logic             sep_q, sep_d;

	logic             out_valid_q;
	logic             pend_q;
	logic [2:0]       kind_q;
	logic [7:0]       text_q;
	logic [3:0]       fg_q;
	logic             last_q;

	logic             res_valid, res_two;
	logic [2:0]       res_kind;
	logic [7:0]       res_text;
	logic [3:0]       res_fg;
	logic             is_digit, out_free, adv_s1, in_acc, out_take;
	logic [13:0]      acc;

	assign cfg_ready = 1'b1;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign acc = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + {6'b0, byte_s1 - CH_ZERO};

	always_comb begin
		res_valid = 1'b0;
		res_two   = 1'b0;
		res_kind  = KIND_TEXT;
		res_text  = 8'h00;
		res_fg    = 4'h0;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		num_d     = num_q;
		sep_d     = sep_q;
		if (!en_q) begin
			res_valid = 1'b1;
			res_text  = byte_s1;
		end else begin
			unique case (phase_q)
				PH_ESC: begin
					if (byte_s1 == CH_LBR) begin
						phase_d = PH_CSI;
						cnt_d   = '0;
						num_d   = '0;
						sep_d   = 1'b0;
					end else begin
						phase_d = PH_NORMAL;
					end
				end
				PH_CSI: begin
					if (is_digit || byte_s1 == CH_SEMI) begin
						if (cnt_q < CNT_W'(MAX_PARAM_CHARS)) begin
							cnt_d = cnt_q + 1'b1;
							if (byte_s1 == CH_SEMI) begin
								sep_d = 1'b1;
							end else if (!sep_q) begin
								num_d = (acc > {4'b0, NUM_MAX}) ? NUM_MAX : acc[NUM_W-1:0];
							end
						end
					end else begin
						phase_d = PH_NORMAL;
						priority if (byte_s1 == CH_M) begin
							if (num_q == 10'd0) begin
								res_valid = 1'b1;
								res_kind  = KIND_RESETCOL;
							end else if (num_q >= 10'd30 && num_q <= 10'd37) begin
								res_valid = 1'b1;
								res_kind  = KIND_SETCOL;
								res_fg    = vga_color(num_q[2:0] - 3'd6, 1'b0);
							end else if (num_q >= 10'd90 && num_q <= 10'd97) begin
								res_valid = 1'b1;
								res_kind  = KIND_SETCOL;
								res_fg    = vga_color(num_q[2:0] - 3'd2, 1'b1);
							end
						end else if (byte_s1 == CH_J) begin
							if (num_q == 10'd2) begin
								res_valid = 1'b1;
								res_two   = 1'b1;
								res_kind  = KIND_CLEAR;
							end
						end else if (byte_s1 == CH_H) begin
							res_valid = 1'b1;
							res_kind  = KIND_HOME;
						end else begin
							res_valid = 1'b0;
						end
					end
				end
				default: begin
					if (byte_s1 == CH_ESC) begin
						phase_d = PH_ESC;
					end else begin
						phase_d   = PH_NORMAL;
						res_valid = 1'b1;
						res_text  = byte_s1;
					end
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_take = out_valid_q && !out_stall;
	assign adv_s1   = valid_s1 && out_free && !pend_q;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b1;
			valid_s1    <= 1'b0;
			phase_q     <= PH_NORMAL;
			cnt_q       <= '0;
			num_q       <= '0;
			sep_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				en_q <= escape_parsing_enable;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				num_q   <= num_d;
				sep_q   <= sep_d;
			end
			if (pend_q && out_take) begin
				pend_q <= 1'b0;
			end else if (adv_s1 && res_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= res_two;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= byte_in;
		end
		if (pend_q && out_take) begin
			kind_q <= KIND_HOME;
			text_q <= 8'h00;
			fg_q   <= 4'h0;
			last_q <= 1'b1;
		end else if (adv_s1 && res_valid) begin
			kind_q <= res_kind;
			text_q <= res_text;
			fg_q   <= res_fg;
			last_q <= !res_two;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign text_byte = text_q;
	assign fg_color  = fg_q;
	assign last      = last_q;

	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (out_valid_q && kind_q == KIND_CLEAR && !last_q))
		else $error("home request pending without clear on output");

	a_pend_home: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !out_stall) |=> (out_valid_q && kind_q == KIND_HOME && last_q))
		else $error("cursor home did not follow clear screen");

	a_text_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_TEXT) |-> (text_q == 8'h00))
		else $error("text byte set on a command result");

	a_fg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_SETCOL) |-> (fg_q == 4'h0))
		else $error("foreground set on a non-colour result");

endmodule

`default_nettype wire

/* tb/ansi_escape_to_display_cmd_core_tb.sv */
// Self-checking testbench for the ANSI escape to display command parser.
module ansi_escape_to_display_cmd_core_tb;
	import aetdc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PARAM_CHARS = 15;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] text;
		logic [3:0] fg;
		logic       last;
	} disp_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] byte_in = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] text_byte;
	logic [3:0] fg_color;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       escape_parsing_enable = 1'b1;

	logic [7:0] byte_q[$];
	disp_cmd_t  pending_cmds[$];
	bit         no_idle = 1'b0;
	int         errors = 0;
	int         bytes_sent = 0;
	int         bytes_queued = 0;
	int         cmds_checked = 0;
	int         cfg_writes = 0;
	int         cycles = 0;

	bit          parse_en = 1'b1;
	phase_t      parse_ph = PH_NORMAL;
	int unsigned param_chars = 0;
	logic [9:0]  first_num = '0;
	bit          semi_seen = 1'b0;

	logic [3:0] normal_pal [8] = '{4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7};

	ansi_escape_to_display_cmd_core #(.MAX_PARAM_CHARS(PARAM_CHARS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.text_byte(text_byte),
		.fg_color(fg_color),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.escape_parsing_enable(escape_parsing_enable)
	);

	always #5 clk = ~clk;

	function automatic void push_cmd(logic [2:0] k, logic [7:0] t, logic [3:0] f, logic l);
		disp_cmd_t c;
		c.kind = k;
		c.text = t;
		c.fg = f;
		c.last = l;
		pending_cmds.push_back(c);
	endfunction

	function automatic void run_final_byte(logic [7:0] c);
		int unsigned code;
		code = first_num;
		parse_ph = PH_NORMAL;
		if (c == CH_M) begin
			if (code == 0)
				push_cmd(KIND_RESETCOL, 8'h00, 4'h0, 1'b1);
			else if (code >= 30 && code <= 37)
				push_cmd(KIND_SETCOL, 8'h00, normal_pal[code - 30], 1'b1);
			else if (code >= 90 && code <= 97)
				push_cmd(KIND_SETCOL, 8'h00, {1'b1, normal_pal[code - 90][2:0]}, 1'b1);
		end else if (c == CH_J) begin
			if (code == 2) begin
				push_cmd(KIND_CLEAR, 8'h00, 4'h0, 1'b0);
				push_cmd(KIND_HOME, 8'h00, 4'h0, 1'b1);
			end
		end else if (c == CH_H) begin
			push_cmd(KIND_HOME, 8'h00, 4'h0, 1'b1);
		end
	endfunction

	function automatic void predict_display_cmds(logic [7:0] c);
		int unsigned acc;
		if (!parse_en) begin
			push_cmd(KIND_TEXT, c, 4'h0, 1'b1);
			return;
		end
		case (parse_ph)
			PH_ESC: begin
				if (c == CH_LBR) begin
					parse_ph = PH_CSI;
					param_chars = 0;
					first_num = '0;
					semi_seen = 1'b0;
				end else begin
					parse_ph = PH_NORMAL;
				end
			end
			PH_CSI: begin
				if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI) begin
					if (param_chars < PARAM_CHARS) begin
						param_chars++;
						if (c == CH_SEMI) begin
							semi_seen = 1'b1;
						end else if (!semi_seen) begin
							acc = first_num * 10 + (c - CH_ZERO);
							first_num = (acc > NUM_MAX) ? NUM_MAX : acc[9:0];
						end
					end
				end else begin
					run_final_byte(c);
				end
			end
			default: begin
				if (c == CH_ESC)
					parse_ph = PH_ESC;
				else
					push_cmd(KIND_TEXT, c, 4'h0, 1'b1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_display_cmds(byte_in);
			bytes_sent++;
		end
		if (!in_valid || !in_stall) begin
			if (byte_q.size() > 0 && (no_idle || $urandom_range(99) >= 16)) begin
				in_valid <= 1'b1;
				byte_in <= byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		disp_cmd_t exp_cmd;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command kind=%0d text=%h fg=%h last=%b",
					$time, kind, text_byte, fg_color, last);
				errors++;
			end else begin
				exp_cmd = pending_cmds.pop_front();
				cmds_checked++;
				if (kind !== exp_cmd.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, exp_cmd.kind, kind);
					errors++;
				end
				if (text_byte !== exp_cmd.text) begin
					$display("%0t: text_byte expected %h got %h", $time, exp_cmd.text, text_byte);
					errors++;
				end
				if (fg_color !== exp_cmd.fg) begin
					$display("%0t: fg_color expected %h got %h", $time, exp_cmd.fg, fg_color);
					errors++;
				end
				if (last !== exp_cmd.last) begin
					$display("%0t: last expected %b got %b", $time, exp_cmd.last, last);
					errors++;
				end
			end
		end
		out_stall <= !no_idle && ($urandom_range(99) < 16);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d commands outstanding",
				cycles, pending_cmds.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_byte(logic [7:0] b);
		byte_q.push_back(b);
		bytes_queued++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_csi(string params, logic [7:0] fin);
		add_byte(CH_ESC);
		add_byte(CH_LBR);
		add_str(params);
		add_byte(fin);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (byte_q.size() != 0 || in_valid || pending_cmds.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_parse_enable(bit val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		escape_parsing_enable <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		parse_en = val;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_stream(int n);
		int    start;
		int    r;
		string s;
		logic [7:0] fin;
		start = bytes_queued;
		while (bytes_queued - start < n) begin
			r = $urandom_range(99);
			if (r < 35) begin
				add_byte(8'($urandom_range(255)));
			end else if (r < 85) begin
				case ($urandom_range(6))
					0: s = "0";
					1: s = "2";
					2: s = $sformatf("%0d", 30 + $urandom_range(7));
					3: s = $sformatf("%0d", 90 + $urandom_range(7));
					4: s = $sformatf("%0d", $urandom_range(1023));
					5: s = $sformatf("%0d", $urandom_range(99999, 1000));
					default: s = "";
				endcase
				if ($urandom_range(3) == 0)
					s = {s, ";", $sformatf("%0d", $urandom_range(99))};
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(20, 10))
						s = {s, ($urandom_range(4) == 0) ? ";" :
							$sformatf("%0d", $urandom_range(9))};
				case ($urandom_range(8))
					0, 1, 2: fin = CH_M;
					3, 4: fin = CH_J;
					5: fin = CH_H;
					6: fin = CH_ESC;
					default: fin = 8'($urandom_range(255));
				endcase
				add_csi(s, fin);
			end else if (r < 93) begin
				add_byte(CH_ESC);
				add_byte(8'($urandom_range(255)));
			end else begin
				add_byte(CH_ESC);
				add_byte(CH_LBR);
				repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_parse_enable(1'b1);

		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte("A");
		add_csi("", CH_M);
		add_csi("31", CH_M);
		add_csi("97", CH_M);
		add_csi("2", CH_J);
		add_csi("", CH_H);
		add_byte(CH_ESC);
		add_byte("x");
		add_csi("4", CH_ESC);
		wait_drained();

		write_parse_enable(1'b0);
		random_stream(200);
		wait_drained();

		write_parse_enable(1'b1);
		no_idle = 1'b1;
		random_stream(400);
		wait_drained();
		no_idle = 1'b0;
		random_stream(450);
		wait_drained();

		write_parse_enable(1'b0);
		random_stream(150);
		wait_drained();

		write_parse_enable(1'b1);
		random_stream(250);
		wait_drained();

		$display("Sent %0d bytes over %0d parsing enable writes, checked %0d commands",
			bytes_sent, cfg_writes, cmds_checked);
		$display("Covered text, colour, clear, home, dropped and overlong sequences; %0d errors",
			errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
